// File: design/belpa_pkg.sv
// Package for the button edge latch with press-age query.
// Holds the opcode encoding, field widths and the controller/datapath structs.
// No dependencies.
package belpa_pkg;

	localparam int BTN_W = 16;   // width of every button mask port
	localparam int TICK_W = 32;  // width of now_ticks
	localparam int AGE_W = 32;   // width of press_age

	typedef enum logic [1:0] {
		OP_POLL        = 2'd0,
		OP_COMMIT      = 2'd1,
		OP_QUERY       = 2'd2,
		OP_POLL_COMMIT = 2'd3
	} opcode_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;    // input transfer: run poll/commit, latch query operands
		logic scan_step; // evaluate one stored timestamp
		logic load_out;  // capture the result into the output register
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic in_is_query; // opcode on the input port asks for a query
		logic scan_last;   // current scan entry is the last button
	} dp_status_t;

endpackage

// File: design/button_edge_latch_press_age_unit.sv
// Top level of the button edge latch with press-age query.
// Instantiates belpa_ctrl and belpa_dp; uses belpa_pkg.
//
// Usage:
//   The input channel (in_valid/in_ready) carries one command per transfer:
//   opcode, focused, held_buttons, query_mask and now_ticks. Poll latches
//   rising/falling edges and stamps press times, commit copies the latches
//   into the frame registers, poll-then-commit does both, query looks for the
//   youngest press age among masked buttons with a known press time.
//   Every command yields exactly one result on the output channel
//   (out_valid/out_ready): the three frame masks after the step, plus
//   press_age and age_valid (both zero unless a query found a button).
//
//   Poll and commit work in the transfer cycle; the result is then loaded into the
//   output register, and no new command is taken before that. A query walks the
//   stored timestamps one button per cycle through a single subtract/compare
//   unit before its result is loaded, and takes no new command until then.
//
//   Reset clears all masks, latches and known bits; the output is empty.
//   When the receiver stalls, the result holds in the output register and the
//   following command is still accepted and worked on; it waits in the
//   datapath until the output register frees up.
module button_edge_latch_press_age_unit #(
	parameter int BUTTON_COUNT = 16,
	parameter int TIME_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  opcode,
	input  logic        focused,
	input  logic [15:0] held_buttons,
	input  logic [15:0] query_mask,
	input  logic [31:0] now_ticks,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] frame_held,
	output logic [15:0] frame_pressed,
	output logic [15:0] frame_released,
	output logic [31:0] press_age,
	output logic        age_valid
);
	import belpa_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;

	// Controller: decides when to take a command, scan, and hand off.
	belpa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// Datapath: latches, frame registers, timestamps, age scan, output hold.
	belpa_dp #(
		.BUTTON_COUNT (BUTTON_COUNT),
		.TIME_BITS    (TIME_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.opcode         (opcode),
		.focused        (focused),
		.held_buttons   (held_buttons),
		.query_mask     (query_mask),
		.now_ticks      (now_ticks),
		.frame_held     (frame_held),
		.frame_pressed  (frame_pressed),
		.frame_released (frame_released),
		.press_age      (press_age),
		.age_valid      (age_valid)
	);

`ifndef NO_ASSERTIONS
	// One command at a time: a transfer closes the input until its result is loaded.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input accepted twice in a row");

	// A result appears only after a command was taken and worked on.
	a_out_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result raised without a command in work");

	// No press time found means a zero age.
	a_age_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !age_valid) |-> (press_age == '0))
		else $error("nonzero press age without a valid flag");
`endif

endmodule

// File: design/belpa_ctrl.sv
// Controller state machine of the button edge latch.
// Sequences accept, timestamp scan and result handoff; uses belpa_pkg.
module belpa_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  logic                   out_ready,
	input  belpa_pkg::dp_status_t  status,
	output belpa_pkg::ctrl_cmd_t   cmd
);
	import belpa_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EMIT
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		cmd.accept    = (state_q == ST_IDLE) && in_valid;
		cmd.scan_step = (state_q == ST_SCAN);
		cmd.load_out  = (state_q == ST_EMIT) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// raise valid on a new result, drop it once the held one is taken
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= status.in_is_query ? ST_SCAN : ST_EMIT;
					end
				end
				ST_SCAN: begin
					if (status.scan_last) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// File: design/belpa_dp.sv
// Datapath of the button edge latch: edge latches, frame registers,
// per-button press timestamps, age scan and output register; uses belpa_pkg.
module belpa_dp #(
	parameter int BUTTON_COUNT = 16,
	parameter int TIME_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  belpa_pkg::ctrl_cmd_t  cmd,
	output belpa_pkg::dp_status_t status,
	input  logic [1:0]            opcode,
	input  logic                  focused,
	input  logic [15:0]           held_buttons,
	input  logic [15:0]           query_mask,
	input  logic [31:0]           now_ticks,
	output logic [15:0]           frame_held,
	output logic [15:0]           frame_pressed,
	output logic [15:0]           frame_released,
	output logic [31:0]           press_age,
	output logic                  age_valid
);
	import belpa_pkg::*;

	localparam int NB = BUTTON_COUNT;
	localparam int IDX_W = (NB > 1) ? $clog2(NB) : 1;

	opcode_t             op;
	logic                do_poll;
	logic                do_commit;
	logic [NB-1:0]       held_in;
	logic [NB-1:0]       rise;
	logic [NB-1:0]       fall;
	logic [NB-1:0]       pend_p_next;
	logic [NB-1:0]       pend_r_next;
	logic [NB-1:0]       polled_next;
	logic [TIME_BITS-1:0] now_in;

	logic [NB-1:0]        prev_held_q;
	logic [NB-1:0]        polled_held_q;
	logic [NB-1:0]        pend_p_q;
	logic [NB-1:0]        pend_r_q;
	logic [NB-1:0]        comm_held_q;
	logic [NB-1:0]        comm_p_q;
	logic [NB-1:0]        comm_r_q;
	logic [NB-1:0]        known_q;
	logic [TIME_BITS-1:0] press_time_q [NB];

	logic [NB-1:0]        qmask_q;
	logic [TIME_BITS-1:0] now_q;
	logic [IDX_W-1:0]     idx_q;
	logic                 found_q;
	logic [TIME_BITS-1:0] best_q;

	logic [TIME_BITS-1:0] entry_time;
	logic [TIME_BITS-1:0] entry_age;
	logic                 entry_sel;
	logic [AGE_W-1:0]     age_sat;

	assign op        = opcode_t'(opcode);
	assign do_poll   = (op == OP_POLL) || (op == OP_POLL_COMMIT);
	assign do_commit = (op == OP_COMMIT) || (op == OP_POLL_COMMIT);
	assign held_in   = focused ? NB'(held_buttons) : '0;
	assign rise      = held_in & ~prev_held_q;
	assign fall      = prev_held_q & ~held_in;
	assign now_in    = TIME_BITS'(now_ticks);

	assign pend_p_next = do_poll ? (pend_p_q | rise) : pend_p_q;
	assign pend_r_next = do_poll ? (pend_r_q | fall) : pend_r_q;
	assign polled_next = do_poll ? held_in : polled_held_q;

	assign status.in_is_query = (op == OP_QUERY);
	assign status.scan_last   = (idx_q == IDX_W'(NB - 1));

	// Poll and commit happen in the transfer cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_held_q   <= '0;
			polled_held_q <= '0;
			pend_p_q      <= '0;
			pend_r_q      <= '0;
			comm_held_q   <= '0;
			comm_p_q      <= '0;
			comm_r_q      <= '0;
			known_q       <= '0;
		end else if (cmd.accept) begin
			if (do_poll) begin
				prev_held_q   <= held_in;
				polled_held_q <= held_in;
				known_q       <= known_q | rise;
			end
			if (do_commit) begin
				comm_held_q <= polled_next;
				comm_p_q    <= pend_p_next;
				comm_r_q    <= pend_r_next;
				pend_p_q    <= '0;
				pend_r_q    <= '0;
			end else begin
				pend_p_q <= pend_p_next;
				pend_r_q <= pend_r_next;
			end
		end
	end

	// Timestamps are read only where known, so they need no reset.
	always_ff @(posedge clk) begin
		for (int b = 0; b < NB; b++) begin
			if (cmd.accept && do_poll && rise[b]) begin
				press_time_q[b] <= now_in;
			end
		end
	end

	// Scan: one stored timestamp per cycle, keep the smallest age.
	assign entry_time = press_time_q[idx_q];
	assign entry_sel  = known_q[idx_q] && qmask_q[idx_q];
	assign entry_age  = (now_q >= entry_time) ? (now_q - entry_time) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			found_q <= 1'b0;
			best_q  <= '0;
			qmask_q <= '0;
			now_q   <= '0;
		end else if (cmd.accept) begin
			idx_q   <= '0;
			found_q <= 1'b0;
			best_q  <= '0;
			qmask_q <= NB'(query_mask);
			now_q   <= now_in;
		end else if (cmd.scan_step) begin
			idx_q <= idx_q + IDX_W'(1);
			if (entry_sel && (!found_q || (entry_age < best_q))) begin
				found_q <= 1'b1;
				best_q  <= entry_age;
			end
		end
	end

	generate
		if (TIME_BITS > AGE_W) begin : g_sat
			assign age_sat = (|best_q[TIME_BITS-1:AGE_W]) ? '1 : best_q[AGE_W-1:0];
		end else begin : g_ext
			assign age_sat = AGE_W'(best_q);
		end
	endgenerate

	// Output register; frame fields show the state after the step.
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			frame_held     <= BTN_W'(comm_held_q);
			frame_pressed  <= BTN_W'(comm_p_q);
			frame_released <= BTN_W'(comm_r_q);
			press_age      <= age_sat;
			age_valid      <= found_q;
		end
	end

endmodule

// File: tb/belpa_frame_checker.sv
// Checker for button_edge_latch_press_age_unit: keeps its own copy of the button
// latches, frame registers and press stamps, and checks every result transfer.
// Depends on belpa_pkg.
module belpa_frame_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  opcode,
	input  logic        focused,
	input  logic [15:0] held_buttons,
	input  logic [15:0] query_mask,
	input  logic [31:0] now_ticks,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [15:0] frame_held,
	input  logic [15:0] frame_pressed,
	input  logic [15:0] frame_released,
	input  logic [31:0] press_age,
	input  logic        age_valid,
	output int          fail_count,
	output int          frames_due_count
);
	timeunit 1ns;
	timeprecision 1ps;
	import belpa_pkg::*;

	typedef struct packed {
		logic [BTN_W-1:0] held;
		logic [BTN_W-1:0] pressed;
		logic [BTN_W-1:0] released;
		logic [AGE_W-1:0] age;
		logic             age_ok;
	} frame_result_t;

	frame_result_t frames_due[$];
	int bad_results = 0;
	int due_count = 0;

	logic [BTN_W-1:0]  last_sample;
	logic [BTN_W-1:0]  sample_held;
	logic [BTN_W-1:0]  press_latch;
	logic [BTN_W-1:0]  release_latch;
	logic [BTN_W-1:0]  shown_held;
	logic [BTN_W-1:0]  shown_pressed;
	logic [BTN_W-1:0]  shown_released;
	logic [BTN_W-1:0]  stamp_known;
	logic [TICK_W-1:0] press_stamp [BTN_W];

	assign fail_count = bad_results;
	assign frames_due_count = due_count;

	// Advance the button state by one command and give the frame it should show.
	task automatic apply_command(input opcode_t op, input logic foc,
			input logic [BTN_W-1:0] held, input logic [BTN_W-1:0] qmask,
			input logic [TICK_W-1:0] ticks, output frame_result_t res);
		logic [BTN_W-1:0] sample;
		logic [BTN_W-1:0] rise;
		logic [BTN_W-1:0] fall;
		logic [AGE_W-1:0] age;
		res = '0;
		if (op == OP_POLL || op == OP_POLL_COMMIT) begin
			sample = foc ? held : '0;
			rise = sample & ~last_sample;
			fall = last_sample & ~sample;
			sample_held = sample;
			press_latch = press_latch | rise;
			release_latch = release_latch | fall;
			last_sample = sample;
			for (int b = 0; b < BTN_W; b++) begin
				if (rise[b]) begin
					press_stamp[b] = ticks;
					stamp_known[b] = 1'b1;
				end
			end
		end
		if (op == OP_COMMIT || op == OP_POLL_COMMIT) begin
			shown_held = sample_held;
			shown_pressed = press_latch;
			shown_released = release_latch;
			press_latch = '0;
			release_latch = '0;
		end
		if (op == OP_QUERY) begin
			for (int b = 0; b < BTN_W; b++) begin
				if (stamp_known[b] && qmask[b]) begin
					// a stamp later than now counts as a fresh press
					age = (ticks >= press_stamp[b]) ? ticks - press_stamp[b] : '0;
					if (!res.age_ok || age < res.age) begin
						res.age = age;
						res.age_ok = 1'b1;
					end
				end
			end
		end
		res.held = shown_held;
		res.pressed = shown_pressed;
		res.released = shown_released;
	endtask

	function automatic bit field_differs(input string label, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %h, got %h", $time, label, want, got);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		frame_result_t want;
		frame_result_t next_frame;
		bit bad;
		if (!arst_n) begin
			last_sample = '0;
			sample_held = '0;
			press_latch = '0;
			release_latch = '0;
			shown_held = '0;
			shown_pressed = '0;
			shown_released = '0;
			stamp_known = '0;
			for (int b = 0; b < BTN_W; b++)
				press_stamp[b] = '0;
		end else begin
			// a result always leaves after its command was taken, so check first
			if (out_valid && out_ready) begin
				if (frames_due.size() == 0) begin
					$display("%0t ns: result transfer with no frame outstanding, got %h %h %h %h %b",
						$time, frame_held, frame_pressed, frame_released, press_age, age_valid);
					bad_results++;
				end else begin
					want = frames_due.pop_front();
					bad = field_differs("frame_held", 32'(want.held), 32'(frame_held));
					bad |= field_differs("frame_pressed", 32'(want.pressed), 32'(frame_pressed));
					bad |= field_differs("frame_released", 32'(want.released),
						32'(frame_released));
					bad |= field_differs("press_age", want.age, press_age);
					bad |= field_differs("age_valid", 32'(want.age_ok), 32'(age_valid));
					if (bad)
						bad_results++;
				end
			end
			if (in_valid && in_ready) begin
				apply_command(opcode_t'(opcode), focused, held_buttons, query_mask, now_ticks,
					next_frame);
				frames_due.push_back(next_frame);
			end
			due_count = frames_due.size();
		end
	end

endmodule

// File: tb/tb_button_edge_latch_press_age_unit.sv
// Testbench top for button_edge_latch_press_age_unit: drives commands and random
// back-pressure, and gives the verdict from belpa_frame_checker's failure count.
// Depends on belpa_pkg, belpa_frame_checker and the unit under test.
module tb_button_edge_latch_press_age_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import belpa_pkg::*;

	localparam int RANDOM_COMMANDS = 1750;
	localparam int HOLD_OFF_CYCLES = 300;
	// Slowest command is a query, which scans every button; with long sender gaps
	// and receiver stalls added, the limit still covers the whole run.
	localparam int CYCLE_LIMIT = 800000;
	// Quiet time after the last result: covers a full query scan and then some.
	localparam int SETTLE_CYCLES = 40;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  opcode = '0;
	logic        focused = 1'b0;
	logic [15:0] held_buttons = '0;
	logic [15:0] query_mask = '0;
	logic [31:0] now_ticks = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [15:0] frame_held;
	logic [15:0] frame_pressed;
	logic [15:0] frame_released;
	logic [31:0] press_age;
	logic        age_valid;

	int fail_count;
	int frames_due_count;

	// Shared knobs: percentage of idle cycles on both sides, and a one-shot
	// request for the receiver to hold off (the receiver clears it when done).
	int idle_pct = 20;
	int hold_off_request = 0;
	int cycle_count = 0;

	// Current stimulus state: held mask evolves by a few toggles, time mostly
	// moves forward so press ages stay meaningful.
	logic [15:0] held_now = '0;
	logic [31:0] tick_now = '0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	button_edge_latch_press_age_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.opcode        (opcode),
		.focused       (focused),
		.held_buttons  (held_buttons),
		.query_mask    (query_mask),
		.now_ticks     (now_ticks),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.frame_held    (frame_held),
		.frame_pressed (frame_pressed),
		.frame_released(frame_released),
		.press_age     (press_age),
		.age_valid     (age_valid)
	);

	belpa_frame_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.opcode          (opcode),
		.focused         (focused),
		.held_buttons    (held_buttons),
		.query_mask      (query_mask),
		.now_ticks       (now_ticks),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.frame_held      (frame_held),
		.frame_pressed   (frame_pressed),
		.frame_released  (frame_released),
		.press_age       (press_age),
		.age_valid       (age_valid),
		.fail_count      (fail_count),
		.frames_due_count(frames_due_count)
	);

	// Present one command at a falling edge and hold it until the transfer.
	// in_ready is read right at the rising edge, before any register update.
	task automatic send_command(input opcode_t op, input logic foc, input logic [15:0] held,
			input logic [15:0] qmask, input logic [31:0] ticks);
		@(negedge clk);
		in_valid <= 1'b1;
		opcode <= op;
		focused <= foc;
		held_buttons <= held;
		query_mask <= qmask;
		now_ticks <= ticks;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	// Drop valid for a number of cycles.
	task automatic idle_sender(input int cycles);
		@(negedge clk);
		in_valid <= 1'b0;
		repeat (cycles - 1) @(negedge clk);
	endtask

	// Idle now and then; mostly short gaps, sometimes a long one.
	task automatic maybe_idle_sender();
		if ($urandom_range(0, 99) < idle_pct) begin
			if ($urandom_range(0, 9) == 0)
				idle_sender($urandom_range(5, 30));
			else
				idle_sender($urandom_range(1, 3));
		end
	endtask

	// Stop offering and wait until every outstanding frame has come back.
	task automatic wait_for_drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (frames_due_count != 0)
			@(negedge clk);
	endtask

	// Build one random command. Most are well-formed: the held mask changes by
	// a few buttons, time advances, and query masks are the held mask, one
	// button, random bits, all or none. About one in ten is pure noise in every field.
	task automatic send_random_command();
		opcode_t     op;
		logic        foc;
		logic [15:0] qmask;
		int          pick;
		pick = $urandom_range(0, 99);
		if (pick < 10) begin
			send_command(opcode_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
				16'($urandom), 16'($urandom), $urandom);
		end else begin
			pick = $urandom_range(0, 99);
			if (pick < 35)
				op = OP_POLL;
			else if (pick < 50)
				op = OP_COMMIT;
			else if (pick < 80)
				op = OP_QUERY;
			else
				op = OP_POLL_COMMIT;
			// toggle one or two buttons, occasionally a whole new mask
			if ($urandom_range(0, 19) == 0)
				held_now = 16'($urandom);
			else begin
				held_now ^= 16'h1 << $urandom_range(0, 15);
				if ($urandom_range(0, 1) == 1)
					held_now ^= 16'h1 << $urandom_range(0, 15);
			end
			foc = ($urandom_range(0, 9) != 0);
			// advance time; a rare jump anywhere makes stamps later than now
			if ($urandom_range(0, 49) == 0)
				tick_now = $urandom;
			else
				tick_now += $urandom_range(0, 400);
			pick = $urandom_range(0, 99);
			if (pick < 30)
				qmask = held_now;
			else if (pick < 55)
				qmask = 16'h1 << $urandom_range(0, 15);
			else if (pick < 85)
				qmask = 16'($urandom);
			else if (pick < 95)
				qmask = 16'hFFFF;
			else
				qmask = '0;
			send_command(op, foc, held_now, qmask, tick_now);
		end
	endtask

	// Receiver: stall at random, or hold off for a long stretch on request.
	always begin
		@(negedge clk);
		if (hold_off_request != 0) begin
			out_ready <= 1'b0;
			repeat (hold_off_request) @(negedge clk);
			hold_off_request = 0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= idle_pct);
		end
	end

	// Watchdog: end a hung run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin
		// hold reset, then release it away from the rising edge
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: fresh state, extremes of every field, every opcode.
		send_command(OP_QUERY, 1'b1, 16'h0000, 16'hFFFF, 32'd5);        // nothing known yet
		send_command(OP_POLL, 1'b1, 16'hFFFF, 16'h0000, 32'd100);       // every button rises
		send_command(OP_COMMIT, 1'b0, 16'h0000, 16'h0000, 32'd0);
		send_command(OP_QUERY, 1'b1, 16'hFFFF, 16'h0000, 32'd150);      // zero mask
		send_command(OP_QUERY, 1'b1, 16'hFFFF, 16'hFFFF, 32'd150);
		send_command(OP_QUERY, 1'b1, 16'hFFFF, 16'h8000, 32'd50);       // stamp later than now
		send_command(OP_POLL, 1'b0, 16'hFFFF, 16'hFFFF, 32'd200);       // unfocused: all release
		send_command(OP_POLL_COMMIT, 1'b1, 16'h0001, 16'h0000, 32'hFFFF_FFFF);
		send_command(OP_QUERY, 1'b1, 16'h0000, 16'h0001, 32'hFFFF_FFFF); // age zero
		send_command(OP_QUERY, 1'b1, 16'h0000, 16'h8000, 32'hFFFF_FFFF); // large age
		send_command(OP_QUERY, 1'b1, 16'h0000, 16'h0001, 32'd0);         // wrapped time
		send_command(OP_POLL, 1'b1, 16'hAAAA, 16'h0000, 32'd1000);
		send_command(OP_POLL, 1'b1, 16'h5555, 16'h0000, 32'd1010);
		send_command(OP_POLL_COMMIT, 1'b1, 16'h5555, 16'h0000, 32'd1020); // no new edges
		send_command(OP_QUERY, 1'b1, 16'h0000, 16'hAAAA, 32'd1030);
		send_command(OP_QUERY, 1'b1, 16'h0000, 16'hFFFF, 32'd1030);     // youngest wins
		send_command(OP_COMMIT, 1'b1, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF); // latches empty
		send_command(OP_POLL_COMMIT, 1'b1, 16'h0000, 16'h0000, 32'd2000);
		send_command(OP_QUERY, 1'b0, 16'hFFFF, 16'h7FFE, 32'h8000_0000);

		// Random: include one long receiver hold-off while commands keep
		// coming, one full drain, and a stretch with no idling at all.
		for (int i = 0; i < RANDOM_COMMANDS; i++) begin
			if (i == 200)
				hold_off_request = HOLD_OFF_CYCLES;
			if (i == 500)
				wait_for_drain();
			if (i == 800)
				idle_pct = 0;
			if (i == 1100)
				idle_pct = 20;
			maybe_idle_sender();
			send_random_command();
		end

		// Drain, then stay quiet long enough to catch any stray result.
		wait_for_drain();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (fail_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

// File: filelist.f
design/belpa_pkg.sv
design/belpa_ctrl.sv
design/belpa_dp.sv
design/button_edge_latch_press_age_unit.sv
tb/belpa_frame_checker.sv
tb/tb_button_edge_latch_press_age_unit.sv
